@@ rtl/fmmp_pkg.sv @@
// Shared types and constants for the Fibonacci modular matrix power core.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package fmmp_pkg;

    // Index width that is honored; bits of the input above it are ignored.
    localparam int INDEX_WIDTH = 32;

    // Stream data widths: fields padded to whole bytes.
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 32;

    // Bits of the exponent register, limited by the input field width.
    localparam int EXP_W = (INDEX_WIDTH < S_DATA_W) ? INDEX_WIDTH : S_DATA_W;

    // Residue width and the prime modulus 1000000007.
    localparam int VAL_W = 30;
    localparam logic [VAL_W-1:0] MODULUS = 30'd1000000007;

    // Barrett reduction: mu = floor(2^(2*VAL_W) / MODULUS).
    localparam int Q_W = VAL_W + 1;
    localparam logic [Q_W-1:0] BARRETT_MU = 31'd1152921496;

    // Width of a raw product and of the partially reduced remainder (< 3p).
    localparam int PROD_W = 2 * VAL_W;
    localparam int RED_W = VAL_W + 2;

    // Product tag: bit 3 picks square (1) or result (0) target, bits 2:1 the
    // entry, bit 0 the term of the two-term dot product.
    localparam int TAG_W = 4;
    localparam int PIPE_STAGES = 7;

    typedef logic [3:0][VAL_W-1:0] t_mat;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             load;
        logic             issue;
        logic [TAG_W-1:0] tag;
        logic             commit;
        logic             out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_trivial;
        logic exp_last;
        logic pipe_busy;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

@@ rtl/fmmp_dp.sv @@
// Datapath: matrix registers, exponent, the Barrett modular multiply pipeline
// and the output register. Depends on fmmp_pkg; driven by fmmp_ctrl commands.
`default_nettype none

module fmmp_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [fmmp_pkg::S_DATA_W-1:0]   i_s_tdata,
    input  fmmp_pkg::t_cmd                  i_cmd,
    output fmmp_pkg::t_sts                  o_sts,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [fmmp_pkg::M_DATA_W-1:0]   o_m_tdata
);
    import fmmp_pkg::*;

    localparam int Q2_W = 2 * Q_W;
    localparam int QP_W = Q_W + VAL_W;

    // Matrices and exponent.
    t_mat             r_res;
    t_mat             r_sq;
    t_mat             r_tres;
    t_mat             r_tsq;
    logic [EXP_W-1:0] r_exp;
    logic [VAL_W-1:0] r_hold;

    // Pipeline valid and tag shift line, index n belongs to stage n.
    logic [PIPE_STAGES:1]            r_v;
    logic [PIPE_STAGES:1][TAG_W-1:0] r_tag;

    // Stage payload.
    logic [VAL_W-1:0]  r_s1_a;
    logic [VAL_W-1:0]  r_s1_b;
    logic [PROD_W-1:0] r_s2_x;
    logic [Q_W-1:0]    r_s3_q;
    logic [RED_W-1:0]  r_s3_xlo;
    logic [RED_W-1:0]  r_s4_qp;
    logic [RED_W-1:0]  r_s4_xlo;
    logic [RED_W-1:0]  r_s5_r;
    logic [RED_W-1:0]  r_s6_r;
    logic [VAL_W-1:0]  r_s7_r;

    // Output register.
    logic             r_out_v;
    logic [VAL_W-1:0] r_out_data;

    logic [EXP_W-1:0]  w_n;
    logic [1:0]        w_entry;
    logic              w_term;
    t_mat              w_amat;
    logic [VAL_W-1:0]  w_a;
    logic [VAL_W-1:0]  w_b;
    logic [PROD_W-1:0] w_x;
    logic [Q2_W-1:0]   w_q2;
    logic [QP_W-1:0]   w_qp;
    logic [RED_W-1:0]  w_r7;
    logic [VAL_W:0]    w_sum;
    logic [VAL_W:0]    w_sum_red;

    assign w_n = i_s_tdata[EXP_W-1:0];

    // Operand selection for the product named by the issue tag.
    assign w_entry = i_cmd.tag[2:1];
    assign w_term  = i_cmd.tag[0];
    assign w_amat  = i_cmd.tag[3] ? r_sq : r_res;
    assign w_a     = w_amat[{w_entry[1], w_term}];
    assign w_b     = r_sq[{w_term, w_entry[0]}];

    // Multiplies, one per stage.
    assign w_x  = PROD_W'(r_s1_a) * PROD_W'(r_s1_b);
    assign w_q2 = Q2_W'(r_s2_x[PROD_W-1:VAL_W-1]) * Q2_W'(BARRETT_MU);
    assign w_qp = QP_W'(r_s3_q) * QP_W'(MODULUS);

    // Second correction step and the modular add of the two terms.
    assign w_r7      = (r_s6_r >= RED_W'(MODULUS)) ? r_s6_r - RED_W'(MODULUS) : r_s6_r;
    assign w_sum     = (VAL_W+1)'(r_hold) + (VAL_W+1)'(r_s7_r);
    assign w_sum_red = (w_sum >= (VAL_W+1)'(MODULUS)) ? w_sum - (VAL_W+1)'(MODULUS)
                                                        : w_sum;

    // Control registers of the pipeline and output.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            r_out_v <= 1'b0;
        end else begin
            r_v <= {r_v[PIPE_STAGES-1:1], i_cmd.issue};
            if (i_cmd.out_load) begin
                r_out_v <= 1'b1;
            end else if (i_m_tready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // Exponent register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp <= '0;
        end else if (i_cmd.load) begin
            r_exp <= w_n - EXP_W'(1);
        end else if (i_cmd.commit) begin
            r_exp <= r_exp >> 1;
        end
    end

    // Pipeline payload.
    always_ff @(posedge i_clk) begin
        r_tag    <= {r_tag[PIPE_STAGES-1:1], i_cmd.tag};
        r_s1_a   <= w_a;
        r_s1_b   <= w_b;
        r_s2_x   <= w_x;
        r_s3_q   <= w_q2[Q2_W-1:VAL_W+1];
        r_s3_xlo <= r_s2_x[RED_W-1:0];
        r_s4_qp  <= w_qp[RED_W-1:0];
        r_s4_xlo <= r_s3_xlo;
        r_s5_r   <= r_s4_xlo - r_s4_qp;
        r_s6_r   <= (r_s5_r >= RED_W'(MODULUS)) ? r_s5_r - RED_W'(MODULUS) : r_s5_r;
        r_s7_r   <= w_r7[VAL_W-1:0];
    end

    // Matrix state: load, accumulate finished entries, commit per exponent bit.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_res[0] <= (w_n == '0) ? '0 : VAL_W'(1);
            r_res[1] <= '0;
            r_res[2] <= '0;
            r_res[3] <= VAL_W'(1);
            r_sq[0]  <= VAL_W'(1);
            r_sq[1]  <= VAL_W'(1);
            r_sq[2]  <= VAL_W'(1);
            r_sq[3]  <= '0;
        end else if (i_cmd.commit) begin
            if (r_exp[0]) begin
                r_res <= r_tres;
            end
            r_sq <= r_tsq;
        end
        if (r_v[PIPE_STAGES]) begin
            if (!r_tag[PIPE_STAGES][0]) begin
                r_hold <= r_s7_r;
            end else if (r_tag[PIPE_STAGES][3]) begin
                r_tsq[r_tag[PIPE_STAGES][2:1]] <= w_sum_red[VAL_W-1:0];
            end else begin
                r_tres[r_tag[PIPE_STAGES][2:1]] <= w_sum_red[VAL_W-1:0];
            end
        end
    end

    // Output data register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= r_res[0];
        end
    end

    // Status and ports.
    assign o_sts.in_trivial = (w_n[EXP_W-1:1] == '0);
    assign o_sts.exp_last   = (r_exp[EXP_W-1:1] == '0);
    assign o_sts.pipe_busy  = |r_v;
    assign o_sts.out_free   = !r_out_v || i_m_tready;
    assign o_m_tvalid       = r_out_v;
    assign o_m_tdata        = M_DATA_W'(r_out_data);

    // A commit halves the exponent.
    a_commit_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_exp == ($past(r_exp) >> 1))
        else $error("exponent not shifted on commit");

    // Results live in the output register until taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !i_m_tready && !i_cmd.out_load) |=> $stable(r_out_data))
        else $error("pending result changed");

endmodule

`default_nettype wire

@@ rtl/fmmp_ctrl.sv @@
// Controller: sequences load, the sixteen products of each exponent bit,
// pipeline drain, commit and result hand-off. Depends on fmmp_pkg.
`default_nettype none

module fmmp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    input  fmmp_pkg::t_sts i_sts,
    output fmmp_pkg::t_cmd o_cmd
);
    import fmmp_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_ISSUE  = 3'd1;
    localparam logic [2:0] ST_DRAIN  = 3'd2;
    localparam logic [2:0] ST_COMMIT = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    localparam logic [TAG_W-1:0] LAST_TAG = '1;

    logic [2:0]       r_state;
    logic [2:0]       n_state;
    logic [TAG_W-1:0] r_cnt;
    logic [TAG_W-1:0] n_cnt;

    // Next state and commands.
    always_comb begin
        n_state        = r_state;
        n_cnt          = r_cnt;
        o_cmd.load     = 1'b0;
        o_cmd.issue    = 1'b0;
        o_cmd.tag      = r_cnt;
        o_cmd.commit   = 1'b0;
        o_cmd.out_load = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = i_sts.in_trivial ? ST_DONE : ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                o_cmd.issue = 1'b1;
                n_cnt       = r_cnt + TAG_W'(1);
                if (r_cnt == LAST_TAG) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    n_state = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_cnt        = '0;
                n_state      = i_sts.exp_last ? ST_DONE : ST_ISSUE;
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);

    // The output register is loaded only when it can take the item.
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_sts.out_free)
        else $error("result loaded over a pending one");

    // Commit only once every product of the bit has been accumulated.
    a_commit_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> !i_sts.pipe_busy)
        else $error("commit while products in flight");

    // A nontrivial index starts issuing at the first product.
    a_load_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load && !i_sts.in_trivial) |=> (r_state == ST_ISSUE && r_cnt == '0))
        else $error("bad start after load");

endmodule

`default_nettype wire

@@ rtl/fibonacci_modular_matrix_power_core.sv @@
// Top level of the Fibonacci modular matrix power core.
// Instantiates fmmp_ctrl and fmmp_dp; depends on fmmp_pkg.
//
// The core returns F(n) mod 1000000007 for each index n taken on the slave
// stream, by raising [[1,1],[1,0]] to the power n-1 with square-and-multiply.
// One index is worked on at a time; o_s_tready is high only while the core is
// idle, and a finished result waits in an output register, so the next index
// can be taken while the previous result is still pending. For n = 0 or 1 the
// result is loaded straight into the output register, with no products issued.
// Otherwise, for each significant bit of n-1, sixteen modular products are
// issued one per cycle into a seven-stage Barrett multiply pipeline, which
// then drains before the bit is committed.
`default_nettype none

module fibonacci_modular_matrix_power_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Slave stream: tdata[31:0] = fib_index.
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [fmmp_pkg::S_DATA_W-1:0] i_s_tdata,
    // Master stream: tdata[29:0] = fib_value, tdata[31:30] = zero.
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [fmmp_pkg::M_DATA_W-1:0] o_m_tdata
);
    import fmmp_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // Sequencer.
    fmmp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Matrix state, multiply pipeline and output register.
    fmmp_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

`default_nettype wire

@@ tb/sv/tb_fibonacci_modular_matrix_power_core.sv @@
// Testbench for fibonacci_modular_matrix_power_core: streams indexes in, predicts
// F(n) mod 1000000007 by its own 2x2 matrix power and checks every result item.
// Depends on fmmp_pkg and the core's RTL only.
`timescale 1ns / 100ps

module tb_fibonacci_modular_matrix_power_core;

    import fmmp_pkg::*;

    localparam longint unsigned FIB_PRIME      = 64'd1000000007;
    localparam int              IDLE_PERCENT   = 28;
    localparam int              WATCHDOG_LIMIT = 5000;
    localparam int              SETTLE_CYCLES  = 50;

    typedef logic [3:0][VAL_W-1:0] t_mod_mat;

    logic                i_clk    = 1'b0;
    logic                i_rst_n  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                m_tready = 1'b0;
    logic                o_s_tready;
    logic                o_m_tvalid;
    logic [M_DATA_W-1:0] o_m_tdata;

    // While set, neither side of the stream inserts idle cycles.
    bit steady = 1'b0;

    // Expected fib_value of every index taken and not yet answered, oldest first.
    logic [VAL_W-1:0] pending_fib_values[$];
    int               mismatch_count = 0;
    int               quiet_cycles   = 0;

    fibonacci_modular_matrix_power_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),      // [31:0] fib_index
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata)     // [29:0] fib_value, [31:30] zero
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Modular 2x2 matrix product, row-major entries.
    function automatic t_mod_mat mat_mul_mod(t_mod_mat a, t_mod_mat b);
        t_mod_mat prod;
        for (int r = 0; r < 2; r++) begin
            for (int c = 0; c < 2; c++) begin
                prod[2*r+c] = VAL_W'(((64'(a[2*r]) * 64'(b[c])) % FIB_PRIME
                    + (64'(a[2*r+1]) * 64'(b[2+c])) % FIB_PRIME) % FIB_PRIME);
            end
        end
        return prod;
    endfunction

    // F(n) mod p: top-left entry of [[1,1],[1,0]]^(n-1), scanning exponent bits LSB first.
    function automatic logic [VAL_W-1:0] fibonacci_mod(logic [S_DATA_W-1:0] fib_index);
        logic [63:0] n;
        logic [63:0] exponent;
        t_mod_mat    acc;
        t_mod_mat    sq;
        n = 64'(fib_index);
        if (INDEX_WIDTH < 64) begin
            n = n & ((64'd1 << INDEX_WIDTH) - 64'd1);
        end
        if (n == 64'd0) begin
            return '0;
        end
        acc = {VAL_W'(1), VAL_W'(0), VAL_W'(0), VAL_W'(1)};
        sq  = {VAL_W'(0), VAL_W'(1), VAL_W'(1), VAL_W'(1)};
        exponent = n - 64'd1;
        while (exponent != 64'd0) begin
            if (exponent[0]) begin
                acc = mat_mul_mod(acc, sq);
            end
            exponent = exponent >> 1;
            sq = mat_mul_mod(sq, sq);
        end
        return acc[0];
    endfunction

    // Index of random bit length, so that most items are short and a few use all bits.
    function automatic logic [S_DATA_W-1:0] random_index();
        int unsigned         bit_len;
        logic [S_DATA_W-1:0] value;
        bit_len = $urandom_range(0, S_DATA_W);
        value   = $urandom;
        if (bit_len < S_DATA_W) begin
            value = value & ((32'd1 << bit_len) - 32'd1);
        end
        return value;
    endfunction

    // Sends one index item; starts and ends at a falling edge with valid low.
    task automatic send_index(input logic [S_DATA_W-1:0] fib_index);
        if (!steady) begin
            while ($urandom_range(0, 99) < IDLE_PERCENT) begin
                @(negedge i_clk);
            end
        end
        s_tvalid = 1'b1;
        s_tdata  = fib_index;
        @(posedge i_clk);
        while (!o_s_tready) begin
            @(posedge i_clk);
        end
        pending_fib_values.push_back(fibonacci_mod(fib_index));
        @(negedge i_clk);
        s_tvalid = 1'b0;
    endtask

    // Holds the sender until every expected result item has come back.
    task automatic wait_results_drained();
        while (pending_fib_values.size() != 0) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    // The first indexes, zero among them, where the power is trivial or short.
    task automatic test_small_indexes();
        for (int i = 0; i <= 12; i++) begin
            send_index(S_DATA_W'(i));
        end
    endtask

    // Largest indexes and alternating bit patterns, so every index bit is set and clear.
    task automatic test_extreme_indexes();
        send_index(32'hFFFF_FFFF);
        send_index(32'hFFFF_FFFE);
        send_index(32'h8000_0000);
        send_index(32'h8000_0001);
        send_index(32'hAAAA_AAAA);
        send_index(32'h5555_5555);
        send_index(32'h0001_0000);
        send_index(32'h7FFF_FFFF);
    endtask

    // The sender stops until the core has answered everything, then resumes.
    task automatic test_drain_pause();
        for (int i = 0; i < 5; i++) begin
            send_index(random_index());
        end
        wait_results_drained();
        send_index(32'd0);
        for (int i = 0; i < 4; i++) begin
            send_index(random_index());
        end
    endtask

    // A long stretch with both sides always ready.
    task automatic test_back_to_back();
        steady = 1'b1;
        for (int i = 0; i < 80; i++) begin
            send_index(random_index());
        end
        steady = 1'b0;
    endtask

    // Random indexes with random idling on both sides.
    task automatic test_random_indexes();
        for (int i = 0; i < 470; i++) begin
            send_index(random_index());
        end
    endtask

    // Receiver: drops ready at random unless the stream is in a steady stretch.
    always @(negedge i_clk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // Checks each result item against the oldest expected value.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && m_tready) begin
            if (pending_fib_values.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result item, expected none, actual 0x%h",
                         $time, o_m_tdata);
            end else begin
                logic [M_DATA_W-1:0] expected_word;
                expected_word = M_DATA_W'(pending_fib_values.pop_front());
                if (o_m_tdata !== expected_word) begin
                    mismatch_count++;
                    $display("%0t: fib_value mismatch, expected %0d (0x%h), actual %0d (0x%h)",
                             $time, expected_word, expected_word, o_m_tdata, o_m_tdata);
                end
            end
        end
    end

    // Watchdog: ends the run when no item moves on either side for too long.
    always @(posedge i_clk) begin
        if ((s_tvalid && o_s_tready) || (o_m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no item accepted for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Test sequence.
    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_small_indexes();
        test_extreme_indexes();
        test_drain_pause();
        test_back_to_back();
        test_random_indexes();

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
